@@ design/block_bitmap_consistency_checker_macros.svh @@
// Assertion macros for the block bitmap checker.
// A use expects clk and rst_n in scope.
`ifndef BLOCK_BITMAP_CONSISTENCY_CHECKER_MACROS_SVH
`define BLOCK_BITMAP_CONSISTENCY_CHECKER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define BBCC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bbcc assertion failed");

// Next-cycle implication.
`define BBCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bbcc assertion failed");

`else

`define BBCC_ASSERT_IMPL(label, ante, cons)
`define BBCC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ design/bbcc_pkg.sv @@
`timescale 1ns / 1ps

package bbcc_pkg;

  localparam int DATA_BLOCK_COUNT = 56;
  localparam int DATA_START_BLK   = 8;
  localparam int BLOCK_TOTAL      = 64;
  localparam int INODE_LIMIT      = 128;

  localparam int ROW_W    = 3;
  localparam int IDX_W    = ROW_W + 3;
  localparam int MAP_ROWS = (DATA_BLOCK_COUNT + 7) / 8;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_INODE  = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam logic [2:0] KIND_BAD_INODE    = 3'd0;
  localparam logic [2:0] KIND_BAD_BLOCK    = 3'd1;
  localparam logic [2:0] KIND_DUPLICATE    = 3'd2;
  localparam logic [2:0] KIND_NOT_IN_MAP   = 3'd3;
  localparam logic [2:0] KIND_UNREFERENCED = 3'd4;
  localparam logic [2:0] KIND_DONE         = 3'd5;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_REPORT = 2'd1;
  localparam logic [1:0] CMD_CHECK  = 2'd2;
  localparam logic [1:0] CMD_SWEEP  = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  map_byte_index;
    logic [7:0]  map_byte_value;
    logic [6:0]  inode_number;
    logic        inode_marked;
    logic [15:0] link_count;
    logic [31:0] deletion_stamp;
    logic [31:0] direct_block;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  report_kind;
    logic [6:0]  report_inode;
    logic [31:0] report_block;
    logic        last_report;
  } out_item_t;

  // Command handed from the front to the back.
  typedef struct packed {
    logic [1:0]       op;
    logic [2:0]       kind;
    logic [6:0]       inode;
    logic [31:0]      block;
    logic [IDX_W-1:0] idx;
    logic [ROW_W-1:0] row;
    logic [7:0]       byte_val;
  } cmd_t;

  // Queue status seen by both ends.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Bits of a bitmap row that fall on real data blocks.
  function automatic logic [7:0] row_mask(input logic [ROW_W-1:0] row);
    logic [7:0] m;
    m = '0;
    for (int k = 0; k < 8; k++) begin
      m[k] = ((int'(row) * 8 + k) < DATA_BLOCK_COUNT);
    end
    return m;
  endfunction

endpackage

@@ design/bbcc_front.sv @@
`timescale 1ns / 1ps

module bbcc_front import bbcc_pkg::*; (
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  q_stat_t  q_stat,
  output logic     push,
  output cmd_t     push_cmd
);

  logic [31:0] rel_blk;
  logic        bad_inode;
  logic        bad_block;
  logic        keep;

  assign in_ready = !q_stat.full;
  assign rel_blk  = in_data.direct_block - 32'(DATA_START_BLK);

  always_comb begin
    bad_inode = (in_data.link_count == '0) || (in_data.deletion_stamp != '0);
    bad_block = (in_data.direct_block < 32'(DATA_START_BLK)) ||
                (in_data.direct_block >= 32'(BLOCK_TOTAL)) ||
                (rel_blk >= 32'(DATA_BLOCK_COUNT));
    keep              = 1'b0;
    push_cmd.op       = CMD_LOAD;
    push_cmd.kind     = KIND_BAD_INODE;
    push_cmd.inode    = in_data.inode_number;
    push_cmd.block    = in_data.direct_block;
    push_cmd.idx      = rel_blk[IDX_W-1:0];
    push_cmd.row      = in_data.map_byte_index;
    push_cmd.byte_val = in_data.map_byte_value;
    case (in_data.opcode)
      OP_LOAD: begin
        keep = 1'b1;
      end
      OP_INODE: begin
        // drop unmarked and out-of-range inodes
        keep = in_data.inode_marked &&
               ({1'b0, in_data.inode_number} < 8'(INODE_LIMIT));
        if (bad_inode) begin
          push_cmd.op    = CMD_REPORT;
          push_cmd.kind  = KIND_BAD_INODE;
          push_cmd.block = '0;
        end else if (bad_block) begin
          push_cmd.op   = CMD_REPORT;
          push_cmd.kind = KIND_BAD_BLOCK;
        end else begin
          push_cmd.op = CMD_CHECK;
        end
      end
      OP_FINISH: begin
        keep        = 1'b1;
        push_cmd.op = CMD_SWEEP;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = in_valid && in_ready && keep;

endmodule

@@ design/bbcc_queue.sv @@
`timescale 1ns / 1ps

module bbcc_queue import bbcc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output q_stat_t q_stat,
  output cmd_t    head
);

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);
  assign head         = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ design/bbcc_back.sv @@
`timescale 1ns / 1ps

module bbcc_back import bbcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_stat_t   q_stat,
  input  cmd_t      head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_REPORT     = 3'd1;
  localparam logic [2:0] ST_CHECK_RD   = 3'd2;
  localparam logic [2:0] ST_CHECK_EMIT = 3'd3;
  localparam logic [2:0] ST_SWEEP_RD   = 3'd4;
  localparam logic [2:0] ST_SWEEP_BIT  = 3'd5;
  localparam logic [2:0] ST_DONE       = 3'd6;
  localparam logic [2:0] ST_CLEAR      = 3'd7;

  logic [7:0]            map_mem [MAP_ROWS];
  logic [7:0]            use_mem [MAP_ROWS];
  logic [7:0]            rd_row_r;
  logic [7:0]            use_row_r;
  logic                  rd_en;
  logic [ROW_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [ROW_W-1:0]      wr_addr;
  logic [7:0]            wr_data;
  logic                  use_wr_en;
  logic [ROW_W-1:0]      use_wr_addr;
  logic [7:0]            use_wr_data;

  logic [2:0]            state_r, state_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic                  dup_r, dup_nxt;
  logic                  miss_r, miss_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic [2:0]            bit_r, bit_nxt;
  logic [7:0]            pend_r, pend_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_r, out_nxt;
  logic                  out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    dup_nxt       = dup_r;
    miss_nxt      = miss_r;
    row_nxt       = row_r;
    bit_nxt       = bit_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    pop           = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = head.row;
    wr_data       = head.byte_val & row_mask(head.row);
    use_wr_en     = 1'b0;
    use_wr_addr   = row_r;
    use_wr_data   = '0;
    case (state_r)
      ST_CLEAR: begin
        // zero one use-mark row per cycle after reset
        use_wr_en = 1'b1;
        if (row_r == ROW_W'(MAP_ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (!q_stat.empty) begin
          pop     = 1'b1;
          cmd_nxt = head;
          case (head.op)
            CMD_LOAD: begin
              wr_en = ({1'b0, head.row} < 4'(MAP_ROWS));
            end
            CMD_REPORT: begin
              state_nxt = ST_REPORT;
            end
            CMD_CHECK: begin
              rd_en     = 1'b1;
              rd_addr   = head.idx[IDX_W-1:3];
              state_nxt = ST_CHECK_RD;
            end
            CMD_SWEEP: begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              row_nxt   = '0;
              state_nxt = ST_SWEEP_RD;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{cmd_r.kind, cmd_r.inode, cmd_r.block, 1'b1};
          state_nxt     = ST_IDLE;
        end
      end
      ST_CHECK_RD: begin
        dup_nxt     = use_row_r[cmd_r.idx[2:0]];
        miss_nxt    = !rd_row_r[cmd_r.idx[2:0]];
        // set the use mark: write the row back with this bit on
        use_wr_en   = 1'b1;
        use_wr_addr = cmd_r.idx[IDX_W-1:3];
        use_wr_data = use_row_r | (8'd1 << cmd_r.idx[2:0]);
        state_nxt   = ST_CHECK_EMIT;
      end
      ST_CHECK_EMIT: begin
        if (dup_r) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{KIND_DUPLICATE, cmd_r.inode, cmd_r.block, !miss_r};
            dup_nxt       = 1'b0;
            if (!miss_r) begin
              state_nxt = ST_IDLE;
            end
          end
        end else if (miss_r) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{KIND_NOT_IN_MAP, cmd_r.inode, cmd_r.block, 1'b1};
            miss_nxt      = 1'b0;
            state_nxt     = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SWEEP_RD: begin
        pend_nxt  = rd_row_r & ~use_row_r;
        // clear this row's use marks as the sweep passes it
        use_wr_en = 1'b1;
        bit_nxt   = '0;
        state_nxt = ST_SWEEP_BIT;
      end
      ST_SWEEP_BIT: begin
        if (!pend_r[bit_r] || out_free) begin
          if (pend_r[bit_r]) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{KIND_UNREFERENCED, 7'd0,
                              32'(DATA_START_BLK) + 32'({row_r, bit_r}), 1'b0};
          end
          if (bit_r == 3'd7) begin
            if (row_r == ROW_W'(MAP_ROWS - 1)) begin
              state_nxt = ST_DONE;
            end else begin
              row_nxt   = row_r + 1'b1;
              rd_en     = 1'b1;
              rd_addr   = row_r + 1'b1;
              state_nxt = ST_SWEEP_RD;
            end
          end else begin
            bit_nxt = bit_r + 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{KIND_DONE, 7'd0, 32'd0, 1'b1};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      row_r       <= '0;
      dup_r       <= 1'b0;
      miss_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      dup_r       <= dup_nxt;
      miss_r      <= miss_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    bit_r  <= bit_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  // bitmap and use-mark rows: one write port each, one shared read address, registered read data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (use_wr_en) begin
      use_mem[use_wr_addr] <= use_wr_data;
    end
    if (rd_en) begin
      rd_row_r  <= map_mem[rd_addr];
      use_row_r <= use_mem[rd_addr];
    end
  end

endmodule

@@ design/block_bitmap_consistency_checker.sv @@
// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------
// input    | in_valid / in_ready    | in_data  (bbcc_pkg::in_item_t)
// result   | out_valid / out_ready  | out_data (bbcc_pkg::out_item_t)
//
// Input items enter the front at one per cycle while the two-entry command queue has room.
// Back: load written in IDLE; report via REPORT; check via CHECK_RD, CHECK_EMIT (up to two results).
// A finish reads the 7 rows, walks their bits one per cycle unless a result stalls, then reports done.
// rst_n is synchronous and active low; it clears the queue and all control, then the
// CLEAR state zeroes the use-mark rows before the back takes its first command.
// A stalled result holds in the output register and stalls the back; the front keeps filling the queue.
`timescale 1ns / 1ps

`include "block_bitmap_consistency_checker_macros.svh"

module block_bitmap_consistency_checker import bbcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  q_stat_t q_stat;
  logic    push;
  cmd_t    push_cmd;
  logic    pop;
  cmd_t    head;
  logic    out_done;
  logic    out_unref;

  // Front: classify each item and drop those that cause nothing.
  bbcc_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Queue: decouple classification from execution.
  bbcc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .q_stat   (q_stat),
    .head     (head)
  );

  // Back: hold the bitmap and use marks, emit results.
  bbcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_done  = out_valid && (out_data.report_kind == KIND_DONE);
  assign out_unref = out_valid && (out_data.report_kind == KIND_UNREFERENCED);

  `BBCC_ASSERT_IMPL(a_no_push_full, push, !q_stat.full)
  `BBCC_ASSERT_IMPL(a_no_pop_empty, pop, !q_stat.empty)
  `BBCC_ASSERT_IMPL(a_done_is_last, out_done, out_data.last_report)
  `BBCC_ASSERT_IMPL(a_unref_not_last, out_unref, !out_data.last_report)

endmodule

@@ bench/tb_block_bitmap_consistency_checker.sv @@
`timescale 1ns / 1ps

module tb_block_bitmap_consistency_checker;
  import bbcc_pkg::*;

  // Opcode 3 has no meaning in the block; it must pass without a trace.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 480;
  localparam int DRAIN_AT     = 160;    // random item index of the mid-run pause
  localparam int CHOKE_AT     = 300;    // random item index of the long receiver hold
  localparam int LONG_HOLD    = 400;    // cycles the receiver holds off in one go
  localparam int SETTLE       = 150;    // quiet cycles after the last result
  localparam int CYCLE_LIMIT  = 400000;
  localparam int USE_MODEL    = -1;     // directed row: take results from the predictor

  typedef enum int {SINK_FREE, SINK_BUSY, SINK_CHOKED} sink_mode_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Shadow state of the checker: allocation bitmap and per-block use marks.
  logic [DATA_BLOCK_COUNT-1:0] map_shadow = '0;
  logic [DATA_BLOCK_COUNT-1:0] use_shadow = '0;

  out_item_t step_reports[$];     // reports caused by the item just accepted
  out_item_t pending_reports[$];  // reports still owed by the block, oldest first

  in_item_t  dir_stim[$];
  int        dir_count[$];
  out_item_t dir_report[$];

  int   err_count    = 0;
  int   result_count = 0;
  int   cycle_count  = 0;
  int   burst_left   = 0;
  logic hold_request = 1'b0;
  logic hold_served  = 1'b0;

  block_bitmap_consistency_checker i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic out_item_t make_report(input logic [2:0] kind, input logic [6:0] ino,
                                            input logic [31:0] blk);
    out_item_t r;
    r.report_kind  = kind;
    r.report_inode = ino;
    r.report_block = blk;
    r.last_report  = 1'b0;
    return r;
  endfunction

  // Typed expectation of a single-report item: it is always the last one.
  function automatic out_item_t single_report(input logic [2:0] kind, input logic [6:0] ino,
                                              input logic [31:0] blk);
    out_item_t r;
    r = make_report(kind, ino, blk);
    r.last_report = 1'b1;
    return r;
  endfunction

  // Advance the shadow state by one item and fill step_reports with its reports.
  function automatic void predict_step(input in_item_t it);
    int              idx;
    longint unsigned blk;
    out_item_t       tail;
    step_reports.delete();
    case (it.opcode)
      OP_LOAD: begin
        // Bits past the last data block fall off the map.
        for (int k = 0; k < 8; k++) begin
          idx = int'(it.map_byte_index) * 8 + k;
          if (idx < DATA_BLOCK_COUNT) map_shadow[idx] = it.map_byte_value[k];
        end
      end
      OP_INODE: begin
        blk = it.direct_block;
        if (it.inode_marked && int'(it.inode_number) < INODE_LIMIT) begin
          if (it.link_count == 16'd0 || it.deletion_stamp != 32'd0) begin
            // A bad inode stops here; its block is never looked at.
            step_reports.push_back(make_report(KIND_BAD_INODE, it.inode_number, '0));
          end else if (blk < DATA_START_BLK || blk >= BLOCK_TOTAL ||
                       blk - DATA_START_BLK >= DATA_BLOCK_COUNT) begin
            step_reports.push_back(make_report(KIND_BAD_BLOCK, it.inode_number,
                                               it.direct_block));
          end else begin
            idx = int'(blk - DATA_START_BLK);
            if (use_shadow[idx])
              step_reports.push_back(make_report(KIND_DUPLICATE, it.inode_number,
                                                 it.direct_block));
            use_shadow[idx] = 1'b1;
            if (!map_shadow[idx])
              step_reports.push_back(make_report(KIND_NOT_IN_MAP, it.inode_number,
                                                 it.direct_block));
          end
        end
      end
      OP_FINISH: begin
        for (int i = 0; i < DATA_BLOCK_COUNT; i++) begin
          if (map_shadow[i] && !use_shadow[i])
            step_reports.push_back(make_report(KIND_UNREFERENCED, '0,
                                               32'(DATA_START_BLK + i)));
        end
        step_reports.push_back(make_report(KIND_DONE, '0, '0));
        use_shadow = '0;
      end
      default: ;
    endcase
    if (step_reports.size() > 0) begin
      tail = step_reports.pop_back();
      tail.last_report = 1'b1;
      step_reports.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------

  // Fill every bit at random so that fields an opcode ignores still toggle.
  function automatic in_item_t noise_item();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t load_item(input logic [2:0] row, input logic [7:0] val);
    in_item_t it;
    it = noise_item();
    it.opcode         = OP_LOAD;
    it.map_byte_index = row;
    it.map_byte_value = val;
    return it;
  endfunction

  function automatic in_item_t inode_item(input logic [6:0] ino, input logic marked,
                                          input logic [15:0] links, input logic [31:0] stamp,
                                          input logic [31:0] blk);
    in_item_t it;
    it = noise_item();
    it.opcode         = OP_INODE;
    it.inode_number   = ino;
    it.inode_marked   = marked;
    it.link_count     = links;
    it.deletion_stamp = stamp;
    it.direct_block   = blk;
    return it;
  endfunction

  function automatic in_item_t op_item(input logic [1:0] op);
    in_item_t it;
    it = noise_item();
    it.opcode = op;
    return it;
  endfunction

  // Random item: mostly good inode records with in-range blocks, the rest
  // loads, sweeps, bad records and noise.
  function automatic in_item_t random_item();
    int          pick;
    logic [31:0] blk;
    logic [31:0] stamp;
    logic [15:0] links;
    pick = $urandom_range(0, 99);
    if (pick < 6)
      return load_item(3'($urandom_range(0, 7)), 8'($urandom));
    if (pick < 10)
      return op_item(OP_FINISH);
    if (pick < 12)
      return op_item(OP_UNUSED);
    if (pick < 16)
      return inode_item(7'($urandom), 1'b0, 16'($urandom), $urandom, $urandom);
    if (pick < 24) begin
      // Bad inode: no links, a deletion stamp, or both.
      links = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom);
      stamp = (links != 16'd0) ? ($urandom | 32'd1) : (($urandom_range(0, 1) == 0) ? 32'd0
                                                                                   : $urandom);
      return inode_item(7'($urandom), 1'b1, links, stamp, $urandom);
    end
    if (pick < 32) begin
      // Block outside the data area: just below, just above, or anywhere far off.
      case ($urandom_range(0, 2))
        0:       blk = $urandom_range(0, DATA_START_BLK - 1);
        1:       blk = $urandom_range(BLOCK_TOTAL, BLOCK_TOTAL + 200);
        default: blk = $urandom;
      endcase
      if (blk >= DATA_START_BLK && blk < BLOCK_TOTAL) blk = blk + BLOCK_TOTAL;
      links = 16'($urandom_range(1, 65535));
      return inode_item(7'($urandom), 1'b1, links, '0, blk);
    end
    links = 16'($urandom_range(1, 65535));
    blk   = 32'(DATA_START_BLK + $urandom_range(0, DATA_BLOCK_COUNT - 1));
    return inode_item(7'($urandom), 1'b1, links, '0, blk);
  endfunction

  function automatic void add_row(input in_item_t stim, input int count,
                                  input out_item_t report);
    dir_stim.push_back(stim);
    dir_count.push_back(count);
    dir_report.push_back(report);
  endfunction

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------

  // Offer one item, open a random gap between bursts, and queue what it owes once accepted:
  // the typed report for a count of 1, the predictor's for USE_MODEL, else nothing.
  task automatic send_item(input in_item_t it, input int count, input out_item_t typed);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_step(it);
    if (count == USE_MODEL) begin
      foreach (step_reports[i]) pending_reports.push_back(step_reports[i]);
    end else if (count == 1) begin
      pending_reports.push_back(typed);
    end
  endtask

  // Drop valid and hold until every owed report has come back.
  task automatic drain_reports();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  initial begin : stimulus
    out_item_t none;
    logic [7:0] row_vals [8];
    none = '0;
    row_vals = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h0F, 8'hF0, 8'h81, 8'hFF};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Items that never touch the bitmap come first; then every
    // row is written before anything reads it.
    add_row(op_item(OP_UNUSED), 0, none);
    add_row(inode_item(7'd127, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 0, none);
    add_row(inode_item(7'd127, 1'b1, 16'd0, 32'd0, 32'd8), 1,
            single_report(KIND_BAD_INODE, 7'd127, '0));
    add_row(inode_item(7'd0, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'd63), 1,
            single_report(KIND_BAD_INODE, 7'd0, '0));
    add_row(inode_item(7'd5, 1'b1, 16'd1, 32'd1, 32'd20), 1,
            single_report(KIND_BAD_INODE, 7'd5, '0));
    add_row(inode_item(7'd1, 1'b1, 16'd1, 32'd0, 32'd0), 1,
            single_report(KIND_BAD_BLOCK, 7'd1, 32'd0));
    add_row(inode_item(7'd2, 1'b1, 16'h8000, 32'd0, 32'(DATA_START_BLK - 1)), 1,
            single_report(KIND_BAD_BLOCK, 7'd2, 32'(DATA_START_BLK - 1)));
    add_row(inode_item(7'd3, 1'b1, 16'd2, 32'd0, 32'(BLOCK_TOTAL)), 1,
            single_report(KIND_BAD_BLOCK, 7'd3, 32'(BLOCK_TOTAL)));
    add_row(inode_item(7'd127, 1'b1, 16'hFFFF, 32'd0, 32'hFFFF_FFFF), 1,
            single_report(KIND_BAD_BLOCK, 7'd127, 32'hFFFF_FFFF));
    // The last row lies wholly past the data area, so its load changes nothing.
    for (int r = 0; r < 8; r++) add_row(load_item(3'(r), row_vals[r]), 0, none);
    // First and last data block, a duplicate, a block missing from the map,
    // and both reports from one record.
    add_row(inode_item(7'd10, 1'b1, 16'd1, 32'd0, 32'(DATA_START_BLK)), USE_MODEL, none);
    add_row(inode_item(7'd11, 1'b1, 16'd1, 32'd0, 32'(DATA_START_BLK)), USE_MODEL, none);
    add_row(inode_item(7'd12, 1'b1, 16'hFFFF, 32'd0, 32'(BLOCK_TOTAL - 1)), USE_MODEL, none);
    add_row(inode_item(7'd13, 1'b1, 16'd3, 32'd0, 32'd16), USE_MODEL, none);
    add_row(inode_item(7'd14, 1'b1, 16'd3, 32'd0, 32'd16), USE_MODEL, none);
    // Two sweeps back to back: the second sees the use marks cleared.
    add_row(op_item(OP_FINISH), USE_MODEL, none);
    add_row(op_item(OP_FINISH), USE_MODEL, none);
    add_row(inode_item(7'd15, 1'b1, 16'd1, 32'd0, 32'd16), USE_MODEL, none);

    foreach (dir_stim[i]) send_item(dir_stim[i], dir_count[i], dir_report[i]);
    drain_reports();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == DRAIN_AT) drain_reports();
      if (n == CHOKE_AT) begin
        // Start a sweep, then choke the result side while items keep coming.
        send_item(op_item(OP_FINISH), USE_MODEL, none);
        hold_request = 1'b1;
      end
      send_item(random_item(), USE_MODEL, none);
    end

    drain_reports();
    repeat (SETTLE) @(posedge clk);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Receiver: alternate free, busy and choked stretches; serve one long hold.
  // ---------------------------------------------------------------------

  initial begin : result_sink
    sink_mode_t mode;
    int         mode_left;
    mode      = SINK_FREE;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode      = sink_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      case (mode)
        SINK_FREE: out_ready <= 1'b1;
        SINK_BUSY: out_ready <= ($urandom_range(0, 3) != 0);
        default:   out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Checker
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t MISMATCH result %0d %s: got %0h expected %0h",
             $time, result_count, what, got, want);
    err_count++;
  endtask

  // Compare every accepted result, field by field, with the oldest owed report.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected result, kind", 32'(out_data.report_kind), '0);
      end else begin
        want = pending_reports.pop_front();
        if (out_data.report_kind !== want.report_kind)
          report_mismatch("report_kind", 32'(out_data.report_kind), 32'(want.report_kind));
        if (out_data.report_inode !== want.report_inode)
          report_mismatch("report_inode", 32'(out_data.report_inode),
                          32'(want.report_inode));
        if (out_data.report_block !== want.report_block)
          report_mismatch("report_block", out_data.report_block, want.report_block);
        if (out_data.last_report !== want.last_report)
          report_mismatch("last_report", 32'(out_data.last_report), 32'(want.last_report));
      end
      result_count++;
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule

@@ sim.f @@
+incdir+design
design/bbcc_pkg.sv
design/bbcc_front.sv
design/bbcc_queue.sv
design/bbcc_back.sv
design/block_bitmap_consistency_checker.sv
bench/tb_block_bitmap_consistency_checker.sv
